@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, gated off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/dnst_pkg.sv @@
`default_nettype none

package dnst_pkg;

  localparam int ID_W   = 16;
  localparam int IP_W   = 32;
  localparam int CNT16_W = 16;
  localparam int OCC_W  = 7;

  // private ranges: 10/8, 172.16/12, 192.168/16
  localparam logic [7:0] OCT_TEN     = 8'd10;
  localparam logic [7:0] OCT_172     = 8'd172;
  localparam logic [7:0] OCT_172_LO  = 8'd16;
  localparam logic [7:0] OCT_172_HI  = 8'd31;
  localparam logic [7:0] OCT_192     = 8'd192;
  localparam logic [7:0] OCT_168     = 8'd168;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [IP_W-1:0] client;
  } tbl_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/dnst_if.sv @@
`default_nettype none

interface dnst_in_if;
  logic                           valid;
  logic                           ready;
  logic                           qr_flag;
  logic [dnst_pkg::CNT16_W-1:0]   question_count;
  logic [dnst_pkg::CNT16_W-1:0]   answer_count;
  logic [dnst_pkg::ID_W-1:0]      txn_id;
  logic [dnst_pkg::IP_W-1:0]      src_ip;
  logic [dnst_pkg::IP_W-1:0]      dst_ip;

  modport source (output valid, qr_flag, question_count, answer_count,
                  txn_id, src_ip, dst_ip, input ready);
  modport sink   (input valid, qr_flag, question_count, answer_count,
                  txn_id, src_ip, dst_ip, output ready);
endinterface

interface dnst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         alert;
  logic                         matched;
  logic                         query_dropped;
  logic [dnst_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, alert, matched, query_dropped, occupancy,
                  input ready);
  modport sink   (input valid, alert, matched, query_dropped, occupancy,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/dnst_table.sv @@
`default_nettype none

// Query table: one write port, one read port, registered read data.
module dnst_table #(
  parameter int DEPTH = 64,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  dnst_pkg::tbl_entry_t wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output dnst_pkg::tbl_entry_t rdata
);

  dnst_pkg::tbl_entry_t mem [DEPTH];
  dnst_pkg::tbl_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/dnst_match.sv @@
`default_nettype none

// Compare unit: entry vs. lookup key, plus private-source check.
module dnst_match (
  input  dnst_pkg::tbl_entry_t           entry,
  input  logic [dnst_pkg::ID_W-1:0]      key_id,
  input  logic [dnst_pkg::IP_W-1:0]      key_addr,
  input  logic [dnst_pkg::IP_W-1:0]      src_ip,
  output logic                           hit,
  output logic                           src_private
);

  logic [7:0] o0;
  logic [7:0] o1;

  assign o0 = src_ip[31:24];
  assign o1 = src_ip[23:16];

  assign hit = (entry.id == key_id) && (entry.client == key_addr);

  assign src_private = (o0 == dnst_pkg::OCT_TEN) ||
                       ((o0 == dnst_pkg::OCT_172) && (o1 >= dnst_pkg::OCT_172_LO) &&
                        (o1 <= dnst_pkg::OCT_172_HI)) ||
                       ((o0 == dnst_pkg::OCT_192) && (o1 == dnst_pkg::OCT_168));

endmodule

`default_nettype wire

@@ rtl/core/dns_response_spoof_tracker_core.sv @@
// Timing: a query or an ignored message goes from accept through S_RESULT to
// the output register; a response scans the table one entry per cycle
// through the single read port, and on a match also passes S_MOVE_RD and
// S_MOVE_WR. One message at a time; ready returns with the result beat,
// later if that stalls.
// Reset (rst_n low, synchronous): table empty, sequencer idle, no result held.
`default_nettype none

module dns_response_spoof_tracker_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  dnst_in_if.sink     in_msg,
  dnst_out_if.source  out_res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam int OCC_W = dnst_pkg::OCC_W;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_RESULT  = 5'b10000
  } state_t;

  state_t                     state_r,    state_nxt;
  logic [CNT_W-1:0]           count_r,    count_nxt;    // live entries
  logic [CNT_W-1:0]           scan_idx_r, scan_idx_nxt; // next address to read
  logic                       pend_r,     pend_nxt;     // read in flight
  logic [IDX_W-1:0]           pend_idx_r, pend_idx_nxt; // address of that read
  logic [IDX_W-1:0]           hit_idx_r,  hit_idx_nxt;

  // latched message key
  logic [dnst_pkg::ID_W-1:0]  key_id_r,   key_id_nxt;
  logic [dnst_pkg::IP_W-1:0]  key_src_r,  key_src_nxt;
  logic [dnst_pkg::IP_W-1:0]  key_dst_r,  key_dst_nxt;

  // per-message result flags
  logic res_alert_r,   res_alert_nxt;
  logic res_matched_r, res_matched_nxt;
  logic res_drop_r,    res_drop_nxt;

  // output register
  logic              out_valid_r,   out_valid_nxt;
  logic              out_alert_r,   out_alert_nxt;
  logic              out_matched_r, out_matched_nxt;
  logic              out_drop_r,    out_drop_nxt;
  logic [OCC_W-1:0]  out_occ_r,     out_occ_nxt;

  // table ports
  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_waddr;
  dnst_pkg::tbl_entry_t tbl_wdata;
  logic                 tbl_re;
  logic [IDX_W-1:0]     tbl_raddr;
  dnst_pkg::tbl_entry_t tbl_rdata;

  logic                 cmp_hit;
  logic                 src_private;

  logic                 in_acc;
  logic                 is_store;
  logic                 is_lookup;
  logic                 slot_free;
  logic [CNT_W-1:0]     last_idx;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign in_msg.ready = (state_r == S_IDLE);
  assign in_acc       = in_msg.valid && in_msg.ready;
  assign is_store     = !in_msg.qr_flag && (in_msg.question_count != '0);
  assign is_lookup    = in_msg.qr_flag && (in_msg.answer_count != '0);
  assign slot_free    = !out_valid_r || out_res.ready;
  assign last_idx     = count_r - CNT_W'(1);
  assign occ_ext      = {{OCC_W{1'b0}}, count_r};

  dnst_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // compares the entry read last cycle against the latched key
  dnst_match u_match (
    .entry       (tbl_rdata),
    .key_id      (key_id_r),
    .key_addr    (key_dst_r),
    .src_ip      (key_src_r),
    .hit         (cmp_hit),
    .src_private (src_private)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_idx_nxt    = scan_idx_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    hit_idx_nxt     = hit_idx_r;
    key_id_nxt      = key_id_r;
    key_src_nxt     = key_src_r;
    key_dst_nxt     = key_dst_r;
    res_alert_nxt   = res_alert_r;
    res_matched_nxt = res_matched_r;
    res_drop_nxt    = res_drop_r;
    out_valid_nxt   = out_valid_r;
    out_alert_nxt   = out_alert_r;
    out_matched_nxt = out_matched_r;
    out_drop_nxt    = out_drop_r;
    out_occ_nxt     = out_occ_r;

    tbl_we    = 1'b0;
    tbl_waddr = count_r[IDX_W-1:0];
    tbl_wdata = '{id: in_msg.txn_id, client: in_msg.src_ip};
    tbl_re    = 1'b0;
    tbl_raddr = scan_idx_r[IDX_W-1:0];

    // result beat taken downstream
    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_id_nxt      = in_msg.txn_id;
          key_src_nxt     = in_msg.src_ip;
          key_dst_nxt     = in_msg.dst_ip;
          res_alert_nxt   = 1'b0;
          res_matched_nxt = 1'b0;
          res_drop_nxt    = 1'b0;
          state_nxt       = S_RESULT;
          if (is_store) begin
            // append at the tail, or drop when full
            if (count_r < DEPTH_C) begin
              tbl_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              res_drop_nxt = 1'b1;
            end
          end else if (is_lookup && (count_r != '0)) begin
            scan_idx_nxt = '0;
            pend_nxt     = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, compared the cycle after
        if (pend_r && cmp_hit) begin
          hit_idx_nxt = pend_idx_r;
          pend_nxt    = 1'b0;
          state_nxt   = S_MOVE_RD;
        end else if (pend_r && (pend_idx_r == last_idx[IDX_W-1:0])) begin
          pend_nxt  = 1'b0;   // no match: nothing changes
          state_nxt = S_RESULT;
        end else begin
          tbl_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
      end

      S_MOVE_RD: begin
        // fetch the tail entry to fill the freed slot
        tbl_re    = 1'b1;
        tbl_raddr = last_idx[IDX_W-1:0];
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // matched slot equal to tail rewrites itself, harmless
        tbl_we          = 1'b1;
        tbl_waddr       = hit_idx_r;
        tbl_wdata       = tbl_rdata;
        count_nxt       = last_idx;
        res_matched_nxt = 1'b1;
        res_alert_nxt   = !src_private;
        state_nxt       = S_RESULT;
      end

      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_alert_nxt   = res_alert_r;
          out_matched_nxt = res_matched_r;
          out_drop_nxt    = res_drop_r;
          out_occ_nxt     = occ_ext[OCC_W-1:0];
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    scan_idx_r    <= scan_idx_nxt;
    pend_idx_r    <= pend_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    key_id_r      <= key_id_nxt;
    key_src_r     <= key_src_nxt;
    key_dst_r     <= key_dst_nxt;
    res_alert_r   <= res_alert_nxt;
    res_matched_r <= res_matched_nxt;
    res_drop_r    <= res_drop_nxt;
    out_alert_r   <= out_alert_nxt;
    out_matched_r <= out_matched_nxt;
    out_drop_r    <= out_drop_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.alert         = out_alert_r;
  assign out_res.matched       = out_matched_r;
  assign out_res.query_dropped = out_drop_r;
  assign out_res.occupancy     = out_occ_r;

endmodule

`default_nettype wire

@@ rtl/core/dnst_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module dnst_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_alert,
  input logic out_matched
);

  // stalled result beat stays up
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one message at a time: busy right after an accept
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // an alert only comes with a removed entry
  `ASSERT_IMP(a_alert_needs_match, clk, rst_n, out_valid && out_alert, out_matched)

  // reset drops any pending result
  `ASSERT_NXT_ALWAYS(a_reset_clears, clk, !rst_n, !out_valid)

endmodule

bind dns_response_spoof_tracker_core dnst_checker u_dnst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_msg.valid),
  .in_ready    (in_msg.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_alert   (out_res.alert),
  .out_matched (out_res.matched)
);

`default_nettype wire
